[rtl/ccmp_pkg.sv]
`timescale 1ns / 1ps

package ccmp_pkg;

	localparam int MAX_RUN = 64;
	localparam int CNT_W   = $clog2(MAX_RUN + 1);
	localparam int ADDR_W  = 24;
	localparam int DATA_W  = 16;

	localparam logic [7:0] MAX_RUN_B = 8'(MAX_RUN);

	localparam logic [7:0] MODE_WR_B0  = 8'h80;
	localparam logic [7:0] MODE_WR_B1  = 8'hA0;
	localparam logic [7:0] MODE_WR_H0  = 8'h81;
	localparam logic [7:0] MODE_WR_H1  = 8'hA1;
	localparam logic [7:0] MODE_BTN_B  = 8'h88;
	localparam logic [7:0] MODE_BTN_H  = 8'h89;
	localparam logic [7:0] MODE_EQ_B   = 8'hD0;
	localparam logic [7:0] MODE_EQ_H   = 8'hD1;
	localparam logic [7:0] MODE_NE_B   = 8'hD2;
	localparam logic [7:0] MODE_NE_H   = 8'hD3;
	localparam logic [7:0] MODE_SERIAL = 8'h50;

	localparam logic [1:0] STAT_HANDLED = 2'd0;
	localparam logic [1:0] STAT_SKIPPED = 2'd1;
	localparam logic [1:0] STAT_ILLEGAL = 2'd2;
	localparam logic [1:0] STAT_TRUNC   = 2'd3;

	localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00FF;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic              write_valid;
		logic              write_halfword;
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        status;
		logic              last;
	} result_t;

endpackage

[rtl/ccmp_code_if.sv]
`timescale 1ns / 1ps

interface ccmp_code_if
	import ccmp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [7:0]        mode;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] value;
	logic [DATA_W-1:0] mem_data;
	logic              button;
	logic              first_code;

	modport source (
		output valid, mode, address, value, mem_data, button, first_code,
		input  ready
	);
	modport sink (
		input  valid, mode, address, value, mem_data, button, first_code,
		output ready
	);
endinterface

[rtl/ccmp_write_if.sv]
`timescale 1ns / 1ps

interface ccmp_write_if
	import ccmp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              write_valid;
	logic              write_halfword;
	logic [ADDR_W-1:0] write_address;
	logic [DATA_W-1:0] write_data;
	logic [1:0]        status;
	logic              last;

	modport source (
		output valid, write_valid, write_halfword, write_address, write_data, status, last,
		input  ready
	);
	modport sink (
		input  valid, write_valid, write_halfword, write_address, write_data, status, last,
		output ready
	);
endinterface

[rtl/cheat_code_memory_patcher_top.sv]
`timescale 1ns / 1ps

// Cheat code memory patcher.
// code_ch (valid/ready) takes one decoded code per beat; write_ch (valid/ready)
// gives the results, several per code for a serial run, the final one with last set.
// cfg_we/cfg_wdata write the enable bit at any edge; write it only while idle.
// A plain code (write, button write, compare, serial setup, unknown) gives one
// result in the output register at the edge of its beat, and the next code can be
// taken at the same edge that result leaves: one code every cycle while the
// receiver keeps ready high.
// The code after a serial setup expands into N byte writes (N up to 64), one
// per cycle while the receiver keeps ready high, through a single address/data
// accumulator pair; the first write reaches the output register from the run
// state entered at the beat, and the code channel stays not ready until the
// last write of the run is there.
// When the receiver drops ready the result holds in the output register and
// both the run and the code channel wait.
// Reset clears skip and serial state, empties the output register and sets
// the enable bit.
module cheat_code_memory_patcher_top
	import ccmp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	ccmp_code_if.sink    code_ch,
	ccmp_write_if.source write_ch
);

	state_t            state_q;
	logic              enabled_q;
	logic              skip_q;
	logic              pend_q;
	logic [7:0]        run_count_q;
	logic [7:0]        step_q;
	logic [7:0]        inc_q;
	logic [CNT_W-1:0]  remain_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        data_q;
	logic              trunc_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              out_free;
	logic              in_fire;
	logic              run_emit;
	logic              skip_e;
	logic              pend_e;
	logic              skip_d;
	logic              pend_d;
	logic              load_serial;
	logic              start_run;
	logic [CNT_W-1:0]  cnt_sat;
	logic              trunc_sat;
	logic [DATA_W-1:0] cmp_mask;
	logic              cmp_eq;
	result_t           plain_res;
	result_t           run_res;

	assign out_free      = !out_valid_q || write_ch.ready;
	assign code_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire       = code_ch.valid && code_ch.ready;
	assign run_emit      = (state_q == ST_RUN) && out_free;

	assign write_ch.valid          = out_valid_q;
	assign write_ch.write_valid    = res_q.write_valid;
	assign write_ch.write_halfword = res_q.write_halfword;
	assign write_ch.write_address  = res_q.write_address;
	assign write_ch.write_data     = res_q.write_data;
	assign write_ch.status         = res_q.status;
	assign write_ch.last           = res_q.last;

	// first code of a pass sees cleared state
	assign skip_e = code_ch.first_code ? 1'b0 : skip_q;
	assign pend_e = code_ch.first_code ? 1'b0 : pend_q;

	always_comb begin
		if (run_count_q > MAX_RUN_B) begin
			cnt_sat   = CNT_W'(MAX_RUN);
			trunc_sat = 1'b1;
		end else begin
			cnt_sat   = run_count_q[CNT_W-1:0];
			trunc_sat = 1'b0;
		end
	end

	// byte compares use the low bytes, halfword compares odd-numbered modes
	assign cmp_mask = code_ch.mode[0] ? '1 : BYTE_MASK;
	assign cmp_eq   = ((code_ch.mem_data ^ code_ch.value) & cmp_mask) == '0;

	always_comb begin
		plain_res      = '0;
		plain_res.last = 1'b1;
		skip_d         = skip_e;
		pend_d         = pend_e;
		load_serial    = 1'b0;
		start_run      = 1'b0;
		if (!enabled_q) begin
			plain_res.status = STAT_SKIPPED;
		end else if (pend_e) begin
			pend_d = 1'b0;
			if (cnt_sat == '0) begin
				plain_res.status = STAT_HANDLED;
			end else begin
				start_run = 1'b1;
			end
		end else begin
			unique case (code_ch.mode)
				MODE_WR_B0, MODE_WR_B1, MODE_WR_H0, MODE_WR_H1, MODE_BTN_B, MODE_BTN_H: begin
					if (skip_e) begin
						skip_d           = 1'b0;
						plain_res.status = STAT_SKIPPED;
					end else if (code_ch.mode[3] && !code_ch.button) begin
						plain_res.status = STAT_SKIPPED;
					end else begin
						plain_res.write_valid    = 1'b1;
						plain_res.write_halfword = code_ch.mode[0];
						plain_res.write_address  = code_ch.address;
						plain_res.write_data     = code_ch.mode[0] ? code_ch.value
						                                           : (code_ch.value & BYTE_MASK);
						plain_res.status         = STAT_HANDLED;
					end
				end
				MODE_EQ_B, MODE_EQ_H, MODE_NE_B, MODE_NE_H: begin
					if (skip_e) begin
						plain_res.status = STAT_SKIPPED;
					end else begin
						// bit 1 of the mode selects not-equal
						if (cmp_eq == code_ch.mode[1]) begin
							skip_d = 1'b1;
						end
						plain_res.status = STAT_HANDLED;
					end
				end
				MODE_SERIAL: begin
					pend_d           = 1'b1;
					load_serial      = 1'b1;
					plain_res.status = STAT_HANDLED;
				end
				default: begin
					plain_res.status = STAT_ILLEGAL;
				end
			endcase
		end
	end

	always_comb begin
		run_res      = '0;
		run_res.last = (remain_q == CNT_W'(1));
		if (skip_q) begin
			run_res.status = STAT_SKIPPED;
		end else begin
			run_res.write_valid   = 1'b1;
			run_res.write_address = addr_q;
			run_res.write_data    = {8'h00, data_q};
			run_res.status        = trunc_q ? STAT_TRUNC : STAT_HANDLED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enabled_q   <= 1'b1;
			skip_q      <= 1'b0;
			pend_q      <= 1'b0;
			run_count_q <= '0;
			step_q      <= '0;
			inc_q       <= '0;
			remain_q    <= '0;
			trunc_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			if (write_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				skip_q <= skip_d;
				pend_q <= pend_d;
				if (load_serial) begin
					run_count_q <= code_ch.address[15:8];
					step_q      <= code_ch.address[7:0];
					inc_q       <= code_ch.value[7:0];
				end
				if (start_run) begin
					state_q  <= ST_RUN;
					remain_q <= cnt_sat;
					trunc_q  <= trunc_sat;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
			if (run_emit) begin
				out_valid_q <= 1'b1;
				skip_q      <= 1'b0;
				remain_q    <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// shared accumulator walks address and data one write per cycle while the output register is free
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= code_ch.address;
			data_q <= code_ch.value[7:0];
			if (!start_run) begin
				res_q <= plain_res;
			end
		end
		if (run_emit) begin
			addr_q <= addr_q + {{(ADDR_W - 8){1'b0}}, step_q};
			data_q <= data_q + inc_q;
			res_q  <= run_res;
		end
	end

endmodule

[tb/cheat_code_memory_patcher_top_test.sv]
`timescale 1ns / 1ps

module cheat_code_memory_patcher_top_test;
	import ccmp_pkg::*;

	localparam logic [7:0] MODE_UNUSED_LO = 8'h00;
	localparam logic [7:0] MODE_UNUSED_HI = 8'hFF;

	typedef struct {
		logic [7:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] mem_data;
		logic              button;
		logic              first_code;
	} cheat_code_t;

	class patch_predictor;
		bit          enabled = 1'b1;
		bit          skip_next = 1'b0;
		bit          serial_pending = 1'b0;
		logic [7:0]  run_count = '0;
		logic [7:0]  address_step = '0;
		logic [15:0] data_increment = '0;
		result_t     pending_writes[$];
		int          errors = 0;
		int          beats = 0;

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function int outstanding();
			return pending_writes.size();
		endfunction

		function void set_enabled(bit en);
			enabled = en;
		endfunction

		function void clear_state();
			skip_next = 1'b0;
			serial_pending = 1'b0;
			run_count = '0;
			address_step = '0;
			data_increment = '0;
		endfunction

		function void push_result(bit wv, bit hw, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] data, logic [1:0] st);
			result_t r;
			r.write_valid = wv;
			r.write_halfword = hw;
			r.write_address = addr;
			r.write_data = data;
			r.status = st;
			r.last = 1'b0;
			pending_writes.push_back(r);
		endfunction

		function void write_code(bit half, bit gated, cheat_code_t c);
			if (skip_next) begin
				skip_next = 1'b0;
				push_result(1'b0, 1'b0, '0, '0, STAT_SKIPPED);
			end else if (gated && !c.button) begin
				push_result(1'b0, 1'b0, '0, '0, STAT_SKIPPED);
			end else begin
				push_result(1'b1, half, c.address, half ? c.value : (c.value & BYTE_MASK),
					STAT_HANDLED);
			end
		endfunction

		function void compare_code(bit half, bit want_equal, cheat_code_t c);
			logic [DATA_W-1:0] mask;
			mask = half ? 16'hFFFF : BYTE_MASK;
			if (skip_next) begin
				// compares met while skipping keep the skip armed
				push_result(1'b0, 1'b0, '0, '0, STAT_SKIPPED);
			end else begin
				if (((c.mem_data & mask) == (c.value & mask)) != want_equal)
					skip_next = 1'b1;
				push_result(1'b0, 1'b0, '0, '0, STAT_HANDLED);
			end
		endfunction

		function void serial_run(cheat_code_t c);
			logic [7:0]        n_run;
			logic [1:0]        run_stat;
			logic [ADDR_W-1:0] a;
			logic [DATA_W-1:0] d;
			serial_pending = 1'b0;
			n_run = run_count;
			run_stat = STAT_HANDLED;
			if (n_run > MAX_RUN_B) begin
				n_run = MAX_RUN_B;
				run_stat = STAT_TRUNC;
			end
			if (n_run == 8'd0)
				push_result(1'b0, 1'b0, '0, '0, STAT_HANDLED);
			for (int i = 0; i < int'(n_run); i++) begin
				a = c.address + 24'(int'(address_step) * i);
				d = c.value + data_increment * 16'(i);
				if (skip_next) begin
					skip_next = 1'b0;
					push_result(1'b0, 1'b0, '0, '0, STAT_SKIPPED);
				end else begin
					push_result(1'b1, 1'b0, a, d & BYTE_MASK, run_stat);
				end
			end
			run_count = '0;
			address_step = '0;
			data_increment = '0;
		endfunction

		function void note_code(cheat_code_t c);
			if (c.first_code)
				clear_state();
			if (!enabled) begin
				push_result(1'b0, 1'b0, '0, '0, STAT_SKIPPED);
			end else if (serial_pending) begin
				serial_run(c);
			end else begin
				case (c.mode)
					MODE_WR_B0, MODE_WR_B1: write_code(1'b0, 1'b0, c);
					MODE_WR_H0, MODE_WR_H1: write_code(1'b1, 1'b0, c);
					MODE_BTN_B: write_code(1'b0, 1'b1, c);
					MODE_BTN_H: write_code(1'b1, 1'b1, c);
					MODE_EQ_B: compare_code(1'b0, 1'b1, c);
					MODE_EQ_H: compare_code(1'b1, 1'b1, c);
					MODE_NE_B: compare_code(1'b0, 1'b0, c);
					MODE_NE_H: compare_code(1'b1, 1'b0, c);
					MODE_SERIAL: begin
						serial_pending = 1'b1;
						run_count = c.address[15:8];
						address_step = c.address[7:0];
						data_increment = c.value;
						push_result(1'b0, 1'b0, '0, '0, STAT_HANDLED);
					end
					default: push_result(1'b0, 1'b0, '0, '0, STAT_ILLEGAL);
				endcase
			end
			pending_writes[pending_writes.size() - 1].last = 1'b1;
		endfunction

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("beat %0d %s got %0h want %0h", beats, name, got, want));
		endtask

		task check_write(result_t got);
			result_t want;
			if (pending_writes.size() == 0) begin
				report($sformatf("beat %0d arrived with nothing expected", beats));
			end else begin
				want = pending_writes.pop_front();
				check_field("write_valid", got.write_valid, want.write_valid);
				check_field("write_halfword", got.write_halfword, want.write_halfword);
				check_field("write_address", got.write_address, want.write_address);
				check_field("write_data", got.write_data, want.write_data);
				check_field("status", got.status, want.status);
				check_field("last", got.last, want.last);
			end
			beats++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	bit   idle_on;
	int   hold_req;

	patch_predictor patches = new;

	ccmp_code_if  code_ch();
	ccmp_write_if write_ch();

	cheat_code_memory_patcher_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.code_ch  (code_ch),
		.write_ch (write_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("Verification failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin : write_sink
		int stall_left;
		stall_left = 0;
		write_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				write_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				write_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && write_ch.valid && write_ch.ready)
			patches.check_write({write_ch.write_valid, write_ch.write_halfword,
				write_ch.write_address, write_ch.write_data, write_ch.status, write_ch.last});
	end

	// called and returns at a falling edge; valid stays up for a following beat
	task automatic send_code(cheat_code_t c);
		int gap;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			code_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.mode <= c.mode;
		code_ch.address <= c.address;
		code_ch.value <= c.value;
		code_ch.mem_data <= c.mem_data;
		code_ch.button <= c.button;
		code_ch.first_code <= c.first_code;
		do
			@(posedge clk);
		while (!code_ch.ready);
		patches.note_code(c);
		@(negedge clk);
	endtask

	task automatic send(logic [7:0] mode, logic [ADDR_W-1:0] address,
			logic [DATA_W-1:0] value, logic [DATA_W-1:0] mem_data, logic button,
			logic first_code);
		cheat_code_t c;
		c.mode = mode;
		c.address = address;
		c.value = value;
		c.mem_data = mem_data;
		c.button = button;
		c.first_code = first_code;
		send_code(c);
	endtask

	task automatic drain();
		code_ch.valid <= 1'b0;
		while (patches.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_enable(bit en);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		patches.set_enabled(en);
	endtask

	function automatic logic [7:0] pick_write_mode();
		case ($urandom_range(0, 5))
			0: return MODE_WR_B0;
			1: return MODE_WR_B1;
			2: return MODE_WR_H0;
			3: return MODE_WR_H1;
			4: return MODE_BTN_B;
			default: return MODE_BTN_H;
		endcase
	endfunction

	function automatic logic [7:0] pick_compare_mode();
		case ($urandom_range(0, 3))
			0: return MODE_EQ_B;
			1: return MODE_EQ_H;
			2: return MODE_NE_B;
			default: return MODE_NE_H;
		endcase
	endfunction

	// most runs short, a few up to the cap and some past it
	function automatic logic [7:0] pick_run_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(0, 8));
		else if (r < 92)
			return 8'($urandom_range(9, 64));
		return 8'($urandom_range(65, 255));
	endfunction

	function automatic cheat_code_t random_fields();
		cheat_code_t c;
		c.mode = 8'($urandom);
		c.address = 24'($urandom);
		c.value = 16'($urandom);
		c.mem_data = 16'($urandom);
		c.button = 1'($urandom_range(0, 1));
		c.first_code = ($urandom_range(0, 15) == 0);
		return c;
	endfunction

	function automatic cheat_code_t random_compare();
		cheat_code_t c;
		c = random_fields();
		c.mode = pick_compare_mode();
		if ($urandom_range(0, 1))
			c.mem_data[7:0] = c.value[7:0];
		if ($urandom_range(0, 1))
			c.mem_data[15:8] = c.value[15:8];
		return c;
	endfunction

	task automatic random_codes(int n);
		int sent;
		int pick;
		cheat_code_t c;
		cheat_code_t entry;
		sent = 0;
		while (sent < n) begin
			c = random_fields();
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				c.mode = pick_write_mode();
				send_code(c);
				sent++;
			end else if (pick < 40) begin
				send_code(random_compare());
				sent++;
			end else if (pick < 62) begin
				// compare guarding a write, sometimes a chain of two compares
				send_code(random_compare());
				if ($urandom_range(0, 2) == 0)
					send_code(random_compare());
				c.mode = pick_write_mode();
				send_code(c);
				sent += 2;
			end else if (pick < 88) begin
				c.mode = MODE_SERIAL;
				c.address[15:8] = pick_run_len();
				send_code(c);
				entry = random_fields();
				if ($urandom_range(0, 1))
					entry.mode = pick_write_mode();
				send_code(entry);
				sent += 2;
			end else begin
				send_code(c);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		idle_on = 1'b0;
		hold_req = 0;
		code_ch.valid = 1'b0;
		code_ch.mode = '0;
		code_ch.address = '0;
		code_ch.value = '0;
		code_ch.mem_data = '0;
		code_ch.button = 1'b0;
		code_ch.first_code = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		set_enable(1'b1);
		idle_on = 1'b1;

		// plain writes at the field extremes
		send(MODE_WR_B0, 24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
		send(MODE_WR_B1, 24'h000000, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
		send(MODE_WR_H0, 24'h123456, 16'hABCD, 16'h0000, 1'b0, 1'b0);
		send(MODE_WR_H1, 24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
		send(MODE_BTN_B, 24'h00A5A5, 16'h5A5A, 16'h0000, 1'b1, 1'b0);
		send(MODE_BTN_B, 24'h00A5A5, 16'h5A5A, 16'h0000, 1'b0, 1'b0);
		send(MODE_BTN_H, 24'h800000, 16'h8001, 16'h0000, 1'b1, 1'b0);
		send(MODE_BTN_H, 24'h800000, 16'h8001, 16'h0000, 1'b0, 1'b0);
		// byte compare looks at the low byte only
		send(MODE_EQ_B, 24'h000100, 16'h34AB, 16'h12AB, 1'b0, 1'b0);
		send(MODE_WR_B0, 24'h000100, 16'h0011, 16'h0000, 1'b0, 1'b0);
		// failed compare, skipped compare, skipped write
		send(MODE_EQ_B, 24'h000100, 16'h00AB, 16'h00AC, 1'b0, 1'b0);
		send(MODE_EQ_H, 24'h000100, 16'h1234, 16'h1234, 1'b0, 1'b0);
		send(MODE_WR_H0, 24'h000200, 16'h5555, 16'h0000, 1'b1, 1'b0);
		// released button still uses up the skip
		send(MODE_NE_B, 24'h000300, 16'h0077, 16'hFF77, 1'b0, 1'b0);
		send(MODE_BTN_B, 24'h000300, 16'h0099, 16'h0000, 1'b0, 1'b0);
		send(MODE_NE_H, 24'h000300, 16'h1234, 16'h1235, 1'b0, 1'b0);
		// serial setup keeps the skip; only the first write of the run is dropped
		send(MODE_EQ_H, 24'h000400, 16'hFFFF, 16'h7FFF, 1'b0, 1'b0);
		send(MODE_SERIAL, 24'hFF0304, 16'h0010, 16'h0000, 1'b0, 1'b0);
		send(MODE_UNUSED_LO, 24'hFFFFFC, 16'h00F8, 16'h0000, 1'b0, 1'b0);
		send(MODE_SERIAL, 24'h0000FF, 16'h1234, 16'h0000, 1'b0, 1'b0);
		send(MODE_EQ_B, 24'h001000, 16'h0001, 16'h0002, 1'b0, 1'b0);
		// longest count, truncated, with address wrap
		send(MODE_SERIAL, 24'h00FFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
		send(MODE_WR_H0, 24'hFFFF00, 16'h00FF, 16'h0000, 1'b0, 1'b0);
		send(MODE_SERIAL, 24'h004001, 16'h0001, 16'h0000, 1'b0, 1'b0);
		send(MODE_UNUSED_HI, 24'h00F000, 16'hFFF0, 16'h0000, 1'b0, 1'b0);
		send(MODE_UNUSED_LO, 24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0);
		// first code of a pass drops a pending run and a pending skip
		send(MODE_SERIAL, 24'h000201, 16'h0001, 16'h0000, 1'b0, 1'b0);
		send(MODE_WR_B0, 24'h000500, 16'h00AA, 16'h0000, 1'b0, 1'b1);
		send(MODE_EQ_B, 24'h000500, 16'h0001, 16'h0000, 1'b0, 1'b0);
		send(MODE_WR_B0, 24'h000500, 16'h00BB, 16'h0000, 1'b0, 1'b1);

		// disabled: state survives, skip is still armed afterwards
		send(MODE_EQ_B, 24'h000600, 16'h0001, 16'h0000, 1'b0, 1'b0);
		set_enable(1'b0);
		send(MODE_WR_H0, 24'h000600, 16'h1111, 16'h0000, 1'b1, 1'b0);
		send(MODE_SERIAL, 24'h000401, 16'h0001, 16'h0000, 1'b0, 1'b0);
		send(MODE_UNUSED_HI, 24'h000600, 16'h0000, 16'h0000, 1'b0, 1'b0);
		set_enable(1'b1);
		send(MODE_WR_B0, 24'h000600, 16'h0022, 16'h0000, 1'b0, 1'b0);
		send(MODE_WR_B0, 24'h000600, 16'h0033, 16'h0000, 1'b0, 1'b0);

		random_codes(60);
		// receiver holds off while codes keep coming
		hold_req = 300;
		random_codes(50);
		drain();

		set_enable(1'b0);
		random_codes(25);
		set_enable(1'b1);

		// a stretch with no idling on either side
		idle_on = 1'b0;
		random_codes(60);
		idle_on = 1'b1;

		hold_req = 200;
		random_codes(80);

		set_enable(1'b0);
		random_codes(10);
		set_enable(1'b1);
		random_codes(20);

		drain();
		repeat (10) @(posedge clk);
		if (patches.outstanding() != 0)
			patches.report("results still expected at the end");
		if (patches.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/ccmp_pkg.sv
rtl/ccmp_code_if.sv
rtl/ccmp_write_if.sv
rtl/cheat_code_memory_patcher_top.sv
tb/cheat_code_memory_patcher_top_test.sv
